### design/gdd_pkg.sv
// gdd_pkg: shared types, constants and helpers of the date decrementer
`timescale 1ns / 1ps

package gdd_pkg;

   // unit codes of the cmd field
   localparam logic [1:0] CMD_DAYS   = 2'd0;
   localparam logic [1:0] CMD_WEEKS  = 2'd1;
   localparam logic [1:0] CMD_MONTHS = 2'd2;
   localparam logic [1:0] CMD_YEARS  = 2'd3;

   localparam logic [8:0] REM_MOD     = 9'd400;
   localparam logic [8:0] REM_WRAP    = 9'd335; // 65535 mod 400
   localparam logic [8:0] REM_NEG_OFS = 9'd336; // 65536 mod 400
   localparam logic [8:0] REM_NEG_ADD = 9'd64;  // 400 - 336

   // ceil(2^25 / 400): exact quotient by 400 for every 16-bit value
   localparam logic [16:0] REM_RECIP = 17'd83887;
   localparam int          REM_SHIFT = 25;

   localparam logic [4:0] MONTH_LEN [1:12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [1:0]         cmd;
      logic [14:0]        count;
      logic [4:0]         day_in;
      logic [3:0]         month_in;
      logic signed [15:0] year_in;
   } req_type;

   typedef struct packed {
      logic [4:0]         day_out;
      logic [3:0]         month_out;
      logic signed [15:0] year_out;
   } rsp_type;

   // working date plus the unsigned year taken mod 400
   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [8:0]  rem400;
   } date_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_RUN,
      ST_DONE
   } state_type;

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         if (month == 4'd0 || month > 4'd12) begin
            len = 5'd31;
         end else if (month == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
         end else begin
            len = MONTH_LEN[month];
         end
         return len;
      end
   endfunction

endpackage

### design/gdd_rem400.sv
// gdd_rem400: remainder of a 16-bit year by 400 through a reciprocal multiply, quotient registered on start
`timescale 1ns / 1ps

module gdd_rem400 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] value,
   output logic        done,
   output logic [8:0]  rem
);

   logic        busy_ff, busy_in;
   logic [15:0] val_ff, val_in;
   logic [7:0]  quo_ff, quo_in;
   logic [32:0] prod;
   logic [15:0] quo_mul;
   logic [15:0] rem_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      busy_in  = busy_ff;
      val_in   = val_ff;
      quo_in   = quo_ff;
      done     = 1'b0;
      // on start the quotient is registered; while busy the remainder is value minus quotient times 400
      prod     = {17'd0, value} * {16'd0, gdd_pkg::REM_RECIP};
      quo_mul  = {8'd0, quo_ff} * {7'd0, gdd_pkg::REM_MOD};
      rem_wide = val_ff - quo_mul;
      if (start) begin
         busy_in = 1'b1;
         val_in  = value;
         quo_in  = prod[gdd_pkg::REM_SHIFT +: 8];
      end else if (busy_ff) begin
         done    = 1'b1;
         busy_in = 1'b0;
      end
   end

   assign rem = rem_wide[8:0];

endmodule

### design/gdd_step.sv
// gdd_step: one day or one month back, with month and year borrow
`timescale 1ns / 1ps

module gdd_step (
   input  logic              month_mode,
   input  gdd_pkg::date_type cur,
   output gdd_pkg::date_type nxt
);

   logic       leap;
   logic [8:0] signed_rem;
   logic [4:0] prev_len;
   logic [3:0] prev_month;
   logic [8:0] rem_dec;

   always_comb begin
      // remainder of the signed year, from the one of its unsigned bits
      if (cur.year[15]) begin
         if (cur.rem400 >= gdd_pkg::REM_NEG_OFS) begin
            signed_rem = 9'(cur.rem400 - gdd_pkg::REM_NEG_OFS);
         end else begin
            signed_rem = 9'(cur.rem400 + gdd_pkg::REM_NEG_ADD);
         end
      end else begin
         signed_rem = cur.rem400;
      end
      leap = (signed_rem[1:0] == 2'b00) && !(signed_rem inside {9'd100, 9'd200, 9'd300});

      prev_month = 4'(cur.month - 4'd1);
      prev_len   = gdd_pkg::month_days(prev_month, leap);

      if (cur.year == 16'd0) begin
         rem_dec = gdd_pkg::REM_WRAP;
      end else if (cur.rem400 == 9'd0) begin
         rem_dec = 9'(gdd_pkg::REM_MOD - 9'd1);
      end else begin
         rem_dec = 9'(cur.rem400 - 9'd1);
      end

      nxt = cur;
      if (month_mode) begin
         if (cur.month == 4'd1) begin
            // december has 31 days, so the day never needs a clamp here
            nxt.month  = 4'd12;
            nxt.year   = 16'(cur.year - 16'd1);
            nxt.rem400 = rem_dec;
         end else begin
            nxt.month = prev_month;
            if (cur.day > prev_len) begin
               nxt.day = prev_len;
            end
         end
      end else begin
         if (cur.day != 5'd1) begin
            nxt.day = 5'(cur.day - 5'd1);
         end else if (cur.month == 4'd1) begin
            nxt.month  = 4'd12;
            nxt.day    = 5'd31;
            nxt.year   = 16'(cur.year - 16'd1);
            nxt.rem400 = rem_dec;
         end else begin
            nxt.month = prev_month;
            nxt.day   = prev_len;
         end
      end
   end

endmodule

### design/gregorian_date_decrementer_unit.sv
// gregorian_date_decrementer_unit: moves a calendar date back by days, weeks, months or years
//
// An item on req_ (valid/stall) carries cmd, count and the starting date; one result item
// leaves on rsp_ (valid/stall) with the moved date. One item is worked on at a time: req_stall
// is high from acceptance until the result is written to the output register.
// Year mode goes straight to the done state. Day, week and month modes first find the year
// mod 400 through a reciprocal multiply in the mod state, then step the date back one day or
// one month per cycle through a single step unit in the run state, where steps is count for
// days and months and 7 * count for weeks (at most 229369 steps). In the done state the
// result goes to the output register once it is free, and the next item is taken after that.
// The output register lets the next item be accepted while a result still waits; a
// finished item then holds in its last state until rsp_stall drops.
// Reset (synchronous, active high) empties the output register and returns the sequencer
// to idle; no clearing pass is needed.
`timescale 1ns / 1ps

module gregorian_date_decrementer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gdd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gdd_pkg::rsp_type rsp_data
);

   gdd_pkg::state_type state_ff, state_in;
   gdd_pkg::date_type  date_ff, date_in;
   gdd_pkg::date_type  date_step;
   logic               month_mode_ff, month_mode_in;
   logic [17:0]        steps_ff, steps_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gdd_pkg::rsp_type   rsp_ff, rsp_in;

   logic               mod_entry_ff;
   logic               mod_done;
   logic [8:0]         mod_rem;
   logic [4:0]         day_norm;
   logic [3:0]         month_norm;
   logic               out_free;

   gdd_rem400 u_rem400 (
      .clock (clock),
      .reset (reset),
      .start (mod_entry_ff),
      .value (date_ff.year),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   gdd_step u_step (
      .month_mode (month_mode_ff),
      .cur        (date_ff),
      .nxt        (date_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      date_ff       <= date_in;
      month_mode_ff <= month_mode_in;
      steps_ff      <= steps_in;
      rsp_ff        <= rsp_in;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      day_norm   = (req_data.day_in == 5'd0) ? 5'd1 : req_data.day_in;
      month_norm = req_data.month_in;
      if (req_data.month_in == 4'd0) begin
         month_norm = 4'd1;
      end else if (req_data.month_in > 4'd12) begin
         month_norm = 4'd12;
      end
   end

   always_comb begin
      state_in      = state_ff;
      date_in       = date_ff;
      month_mode_in = month_mode_ff;
      steps_in      = steps_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = 1'b1;

      case (state_ff)
         gdd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               date_in.day    = day_norm;
               date_in.month  = month_norm;
               date_in.year   = req_data.year_in;
               date_in.rem400 = '0;
               month_mode_in  = (req_data.cmd == gdd_pkg::CMD_MONTHS);
               if (req_data.cmd == gdd_pkg::CMD_WEEKS) begin
                  steps_in = 18'({req_data.count, 3'b000} - {3'b000, req_data.count});
               end else begin
                  steps_in = {3'b000, req_data.count};
               end
               if (req_data.cmd == gdd_pkg::CMD_YEARS) begin
                  date_in.year = 16'(req_data.year_in - {1'b0, req_data.count});
                  state_in     = gdd_pkg::ST_DONE;
               end else begin
                  state_in = gdd_pkg::ST_MOD;
               end
            end
         end
         gdd_pkg::ST_MOD: begin
            // the remainder unit starts on the first cycle here
            if (mod_done) begin
               date_in.rem400 = mod_rem;
               state_in       = gdd_pkg::ST_RUN;
            end
         end
         gdd_pkg::ST_RUN: begin
            if (steps_ff == '0) begin
               state_in = gdd_pkg::ST_DONE;
            end else begin
               date_in  = date_step;
               steps_in = 18'(steps_ff - 18'd1);
            end
         end
         gdd_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_in.day_out   = date_ff.day;
               rsp_in.month_out = date_ff.month;
               rsp_in.year_out  = date_ff.year;
               rsp_valid_in     = 1'b1;
               state_in         = gdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gdd_pkg::ST_IDLE;
         end
      endcase
   end

   // registered start pulse: high in the first mod cycle, once the year is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_entry_ff <= 1'b0;
      end else begin
         mod_entry_ff <= (state_ff == gdd_pkg::ST_IDLE) && (state_in == gdd_pkg::ST_MOD);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // remainder unit result only arrives while the sequencer waits for it
   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == gdd_pkg::ST_MOD)
      else $error("remainder done outside the mod state");

   // the working month stays in 1 to 12 and the day nonzero while stepping
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdd_pkg::ST_RUN |->
         date_ff.month >= 4'd1 && date_ff.month <= 4'd12 && date_ff.day != 5'd0)
      else $error("working date out of range");

   // each run cycle with steps left consumes exactly one step
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdd_pkg::ST_RUN && steps_ff != '0 |=>
         steps_ff == 18'($past(steps_ff) - 18'd1))
      else $error("step counter skipped");

   // handing over a result shows it and frees the input side
   a_handover: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdd_pkg::ST_DONE && out_free |=>
         rsp_valid && state_ff == gdd_pkg::ST_IDLE)
      else $error("result not handed over");

endmodule

### verif/gregorian_date_decrementer_unit_tb.sv
// self-checking testbench of the gregorian date decrementer unit
`timescale 1ns / 1ps

module gregorian_date_decrementer_unit_tb;

   localparam int CYCLE_LIMIT = 4_000_000;

   // expected dates in acceptance order and the date arithmetic behind them
   class date_scoreboard;
      gdd_pkg::rsp_type expected_dates[$];
      int               errors;

      static function int month_length(int month, logic [15:0] year);
         int yr;
         bit leap;
         yr = $signed(year);
         leap = (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
         case (month)
            2: begin
               return leap ? 29 : 28;
            end
            4, 6, 9, 11: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      function gdd_pkg::rsp_type moved_date(gdd_pkg::req_type item);
         int               d;
         int               m;
         int               steps;
         logic [15:0]      y;
         gdd_pkg::rsp_type result;
         d = (item.day_in == 5'd0) ? 1 : int'(item.day_in);
         m = int'(item.month_in);
         if (m == 0) begin
            m = 1;
         end else if (m > 12) begin
            m = 12;
         end
         y = item.year_in;
         case (item.cmd)
            gdd_pkg::CMD_DAYS, gdd_pkg::CMD_WEEKS: begin
               steps = (item.cmd == gdd_pkg::CMD_WEEKS) ? 7 * int'(item.count) :
                       int'(item.count);
               repeat (steps) begin
                  if (d != 1) begin
                     d--;
                  end else if (m == 1) begin
                     m = 12;
                     d = 31;
                     y--;
                  end else begin
                     m--;
                     d = month_length(m, y);
                  end
               end
            end
            gdd_pkg::CMD_MONTHS: begin
               repeat (item.count) begin
                  if (m == 1) begin
                     m = 12;
                     y--;
                  end else begin
                     m--;
                  end
                  if (d > month_length(m, y)) begin
                     d = month_length(m, y);
                  end
               end
            end
            default: begin
               // years: no clamp, so an out-of-range day passes through
               y = 16'(y - {1'b0, item.count});
            end
         endcase
         result.day_out = 5'(d);
         result.month_out = 4'(m);
         result.year_out = y;
         return result;
      endfunction

      function void note_request(gdd_pkg::req_type item);
         expected_dates.push_back(moved_date(item));
      endfunction

      function void check_result(gdd_pkg::rsp_type got);
         gdd_pkg::rsp_type want;
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected result day %0d month %0d year %0d", $time,
                     got.day_out, got.month_out, got.year_out);
            errors++;
            return;
         end
         want = expected_dates.pop_front();
         if (got.day_out !== want.day_out) begin
            $display("%0t: day_out expected %0d actual %0d", $time, want.day_out, got.day_out);
            errors++;
         end
         if (got.month_out !== want.month_out) begin
            $display("%0t: month_out expected %0d actual %0d", $time,
                     want.month_out, got.month_out);
            errors++;
         end
         if (got.year_out !== want.year_out) begin
            $display("%0t: year_out expected %0d actual %0d", $time,
                     want.year_out, got.year_out);
            errors++;
         end
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   gdd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   gdd_pkg::rsp_type rsp_data;

   date_scoreboard board = new();
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   int cycles = 0;

   gregorian_date_decrementer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   function gdd_pkg::req_type make_req(logic [1:0] cmd, int count, int day, int month,
                                       int year);
      gdd_pkg::req_type item;
      item.cmd = cmd;
      item.count = count[14:0];
      item.day_in = day[4:0];
      item.month_in = month[3:0];
      item.year_in = year[15:0];
      return item;
   endfunction

   // called and returns at a falling edge, with valid low
   task send_item(input gdd_pkg::req_type item);
      int gap;
      gap = sender_calm ? 0 : int'($urandom_range(0, 16));
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = item;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task wait_for_results();
      while (board.pending() != 0) @(posedge clock);
   endtask

   // result side: stall for a drawn number of cycles while an item is offered
   initial begin
      int gap;
      bit taken;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 11) == 0) begin
            receiver_calm = ~receiver_calm;
         end
         gap = receiver_calm ? 0 : int'($urandom_range(0, 16));
         rsp_stall = (gap != 0);
         taken = 1'b0;
         while (!taken) begin
            @(posedge clock);
            if (rsp_valid && !rsp_stall) begin
               taken = 1'b1;
            end else begin
               @(negedge clock);
               if (gap != 0 && rsp_valid) begin
                  gap--;
                  if (gap == 0) begin
                     rsp_stall = 1'b0;
                  end
               end
            end
         end
         board.check_result(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      int         n;
      int         roll;
      int         cnt;
      int         dy;
      int         mon;
      int         yr;
      logic [1:0] op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero day and zero month read as 1
      send_item(make_req(gdd_pkg::CMD_DAYS, 0, 0, 0, 1999));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 1, 2000));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 3, 2000));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 3, 1900));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 3, 2023));
      // leap rule on negative years
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 3, -4));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 3, -100));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 3, -400));
      send_item(make_req(gdd_pkg::CMD_DAYS, 1, 1, 1, -32768));
      // day beyond the month just counts down
      send_item(make_req(gdd_pkg::CMD_DAYS, 5, 31, 2, 2021));
      send_item(make_req(gdd_pkg::CMD_DAYS, 40, 31, 15, -1));
      send_item(make_req(gdd_pkg::CMD_WEEKS, 1, 5, 3, 2024));
      send_item(make_req(gdd_pkg::CMD_WEEKS, 0, 17, 13, 0));
      send_item(make_req(gdd_pkg::CMD_MONTHS, 1, 31, 3, 2024));
      send_item(make_req(gdd_pkg::CMD_MONTHS, 13, 31, 3, 2023));
      send_item(make_req(gdd_pkg::CMD_MONTHS, 0, 31, 2, 2023));
      send_item(make_req(gdd_pkg::CMD_MONTHS, 1, 15, 1, -32768));
      send_item(make_req(gdd_pkg::CMD_MONTHS, 2, 0, 14, 1600));
      send_item(make_req(gdd_pkg::CMD_YEARS, 32767, 31, 2, -32768));
      send_item(make_req(gdd_pkg::CMD_YEARS, 1, 29, 2, -32768));
      send_item(make_req(gdd_pkg::CMD_YEARS, 0, 30, 12, 32767));
      // longest runs of each stepping mode
      send_item(make_req(gdd_pkg::CMD_DAYS, 32767, 31, 12, 32767));
      send_item(make_req(gdd_pkg::CMD_WEEKS, 32767, 1, 1, 100));
      send_item(make_req(gdd_pkg::CMD_MONTHS, 32767, 31, 12, 5));
      req_valid = 1'b0;
      wait_for_results();
      @(negedge clock);

      for (n = 0; n < 100; n++) begin
         op = 2'($urandom_range(0, 3));
         roll = int'($urandom_range(0, 99));
         if (op == gdd_pkg::CMD_YEARS) begin
            cnt = int'($urandom_range(0, 32767));
         end else if (roll < 70) begin
            cnt = int'($urandom_range(0, 40));
         end else if (roll < 92) begin
            cnt = int'($urandom_range(41, 400));
         end else begin
            cnt = int'($urandom_range(401, 3000));
         end
         // keep week items about as long as day items
         if (op == gdd_pkg::CMD_WEEKS && cnt > 40) begin
            cnt = cnt / 7;
         end
         roll = int'($urandom_range(0, 9));
         if (roll < 4) begin
            yr = int'($urandom_range(0, 65535)) - 32768;
         end else if (roll < 8) begin
            yr = (int'($urandom_range(0, 654)) - 327) * 100 + int'($urandom_range(0, 4));
         end else if (roll == 8) begin
            yr = -32768 + int'($urandom_range(0, 2));
         end else begin
            yr = 32767 - int'($urandom_range(0, 2));
         end
         roll = int'($urandom_range(0, 99));
         if (roll < 85) begin
            mon = int'($urandom_range(1, 12));
            dy = (roll < 30) ? 1 :
                 int'($urandom_range(1, date_scoreboard::month_length(mon, yr[15:0])));
         end else begin
            mon = int'($urandom_range(0, 15));
            dy = int'($urandom_range(0, 31));
         end
         if ($urandom_range(0, 11) == 0) begin
            sender_calm = ~sender_calm;
         end
         send_item(make_req(op, cnt, dy, mon, yr));
         if ($urandom_range(0, 19) == 0) begin
            wait_for_results();
            @(negedge clock);
         end
      end
      req_valid = 1'b0;

      wait_for_results();
      repeat (30) @(posedge clock);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
